// ===== hdl/lfsrmt_pkg.sv =====
package lfsrmt_pkg;

  localparam int DATA_W   = 32;
  localparam int WC_W     = 30;
  localparam int ACC_W    = 31;
  localparam int PCT_W    = 7;
  localparam int CFG_IX_W = 2;
  localparam int OUT_TDATA_W = 80;

  localparam logic [DATA_W-1:0] LFSR_TAPS   = 32'hD000_0001;
  localparam logic [DATA_W-1:0] SEED_RESET  = 32'hC0FF_EE12;
  localparam logic [DATA_W-1:0] START_RESET = 32'h0000_1000;
  localparam logic [WC_W-1:0]   COUNT_RESET = 30'd4193280;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
  localparam logic [ACC_W-1:0]  ACC_MAX     = 31'h7FFF_FFFF;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_TEST_START = 2'd0,
    REG_WORD_COUNT = 2'd1,
    REG_START_SEED = 2'd2
  } cfg_ix_t;

  typedef enum logic [1:0] {
    PH_WRITE  = 2'd0,
    PH_VERIFY = 2'd1,
    PH_PASS   = 2'd2,
    PH_FAIL   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [DATA_W-1:0] test_start;
    logic [WC_W-1:0]   word_count;
    logic [DATA_W-1:0] start_seed;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [DATA_W-1:0] lfsr;
    logic [WC_W-1:0]   word_index;
    logic [ACC_W-1:0]  acc;
    logic [PCT_W-1:0]  pct;
  } state_t;

  typedef struct packed {
    logic              finished;
    logic              percent_stepped;
    logic [PCT_W-1:0]  percent;
    logic              mismatch;
    logic              write_enable;
    logic [DATA_W-1:0] pattern;
    logic [DATA_W-1:0] word_address;
    logic [1:0]        status;
  } result_t;

  function automatic logic [DATA_W-1:0] lfsr_next(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] o;
    o = {1'b0, v[DATA_W-1:1]};
    if (v[0]) begin
      o = o ^ LFSR_TAPS;
    end
    return o;
  endfunction

endpackage

// ===== hdl/lfsrmt_cfg.sv =====
module lfsrmt_cfg
  import lfsrmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CFG_IX_W-1:0] index,
  input  logic [DATA_W-1:0]   wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_ix_t'(index))
        REG_TEST_START: cfg_nxt.test_start = wdata;
        REG_WORD_COUNT: cfg_nxt.word_count = wdata[WC_W-1:0];
        REG_START_SEED: cfg_nxt.start_seed = wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.test_start <= START_RESET;
      cfg_r.word_count <= COUNT_RESET;
      cfg_r.start_seed <= SEED_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/lfsrmt_core.sv =====
module lfsrmt_core
  import lfsrmt_pkg::*;
#(
  parameter int ADDR_WIDTH = 32
) (
  input  cfg_t              cfg,
  input  state_t            st,
  input  logic              restart,
  input  logic [DATA_W-1:0] read_data,
  output state_t            st_nxt,
  output result_t           res
);

  logic                  wc_zero;
  logic [DATA_W-1:0]     lfsr_stepped;
  logic [ADDR_WIDTH-1:0] addr_base;
  logic [ADDR_WIDTH-1:0] addr_offs;
  logic [ADDR_WIDTH-1:0] addr;
  logic [DATA_W-1:0]     addr_ext;
  logic [DATA_W-1:0]     pattern;
  logic                  mism;
  logic [DATA_W-1:0]     acc_sum;
  logic [DATA_W:0]       acc_diff;
  logic                  rose;
  logic [DATA_W-1:0]     acc_pre;
  logic [ACC_W-1:0]      acc_nxt;
  logic [PCT_W-1:0]      pct_nxt;
  logic [WC_W-1:0]       idx_inc;
  logic                  last_word;

  assign wc_zero      = (cfg.word_count == '0);
  assign lfsr_stepped = lfsr_next(st.lfsr);

  // byte address of the current word, wrapped to the address width
  assign addr_base = {cfg.test_start[ADDR_WIDTH-1:2], 2'b00};
  assign addr_offs = ADDR_WIDTH'({{(DATA_W-WC_W){1'b0}}, st.word_index} << 2);
  assign addr      = addr_base + addr_offs;
  assign addr_ext  = DATA_W'(addr);
  assign pattern   = lfsr_stepped ^ addr_ext;
  assign mism      = (st.phase == PH_VERIFY) && (read_data != pattern);

  // progress accumulator
  assign acc_sum  = {1'b0, st.acc} + DATA_W'(PCT_FULL);
  assign acc_diff = {1'b0, acc_sum} - {3'b000, cfg.word_count};
  assign rose     = !acc_diff[DATA_W] && (st.pct < PCT_FULL);
  assign acc_pre  = rose ? acc_diff[DATA_W-1:0] : acc_sum;
  assign acc_nxt  = acc_pre[DATA_W-1] ? ACC_MAX : acc_pre[ACC_W-1:0];
  assign pct_nxt  = st.pct + PCT_W'(rose);

  assign idx_inc   = st.word_index + WC_W'(1);
  assign last_word = (idx_inc >= cfg.word_count) || (idx_inc == '0);

  always_comb begin
    st_nxt = st;
    if (restart) begin
      st_nxt.phase      = wc_zero ? PH_FAIL : PH_WRITE;
      st_nxt.lfsr       = cfg.start_seed;
      st_nxt.word_index = '0;
      st_nxt.acc        = '0;
      st_nxt.pct        = '0;
    end else begin
      unique case (st.phase) inside
        PH_WRITE, PH_VERIFY: begin
          if (wc_zero) begin
            st_nxt.phase = PH_FAIL;
          end else if (mism) begin
            st_nxt.lfsr  = lfsr_stepped;
            st_nxt.phase = PH_FAIL;
          end else begin
            st_nxt.lfsr       = lfsr_stepped;
            st_nxt.acc        = acc_nxt;
            st_nxt.pct        = pct_nxt;
            st_nxt.word_index = idx_inc;
            if (last_word) begin
              if (st.phase == PH_WRITE) begin
                st_nxt.phase      = PH_VERIFY;
                st_nxt.lfsr       = cfg.start_seed;
                st_nxt.word_index = '0;
                st_nxt.acc        = '0;
                st_nxt.pct        = '0;
              end else begin
                st_nxt.phase = PH_PASS;
              end
            end
          end
        end
        default: st_nxt = st;
      endcase
    end
  end

  always_comb begin
    res = '0;
    if (restart) begin
      res.status   = wc_zero ? PH_FAIL : PH_WRITE;
      res.finished = wc_zero;
    end else begin
      unique case (st.phase) inside
        PH_WRITE, PH_VERIFY: begin
          if (wc_zero) begin
            res.status   = PH_FAIL;
            res.finished = 1'b1;
          end else if (mism) begin
            res.status       = PH_FAIL;
            res.finished     = 1'b1;
            res.mismatch     = 1'b1;
            res.word_address = addr_ext;
            res.pattern      = pattern;
            res.percent      = st.pct;
          end else begin
            res.status          = st.phase;
            res.word_address    = addr_ext;
            res.pattern         = pattern;
            res.write_enable    = (st.phase == PH_WRITE);
            res.percent         = pct_nxt;
            res.percent_stepped = rose;
            if (last_word && (st.phase == PH_VERIFY)) begin
              res.status   = PH_PASS;
              res.finished = 1'b1;
            end
          end
        end
        default: begin
          res.status   = st.phase;
          res.finished = 1'b1;
          res.percent  = st.pct;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lfsr_memory_test_engine.sv =====
// channel   dir  ports                        item contents (lsb first)
// in        in   in_tvalid/in_tready          tdata: read_data; tuser: restart
// out       out  out_tvalid/out_tready        tdata: address, pattern, flags; tuser: status
// cfg       in   cfg_wr_en/cfg_index/cfg_wdata 0 test_start, 1 word_count, 2 start_seed
//
// one item per cycle sustained while out_tready stays high; each item passes through the
// input register, then lfsr step, address add, compare and progress update into
// the result register
// rst_n is synchronous; state restarts at the write phase with the reset seed
// a stall at out_tready holds the result; one more item waits in the input register
module lfsr_memory_test_engine
  import lfsrmt_pkg::*;
#(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,   // read_data
  input  logic                   in_tuser,   // restart
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // word_address, pattern, write_enable, mismatch, percent, percent_stepped, finished
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,  // status
  input  logic                   cfg_wr_en,
  input  logic [CFG_IX_W-1:0]    cfg_index,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  cfg_t              cfg;
  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [DATA_W-1:0] in_data_r;
  logic              in_restart_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  result_t           out_res_r;
  result_t           res;
  state_t            state_r;
  state_t            state_nxt;
  logic              advance;
  logic              in_take;

  lfsrmt_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  lfsrmt_core #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_core (
    .cfg       (cfg),
    .st        (state_r),
    .restart   (in_restart_r),
    .read_data (in_data_r),
    .st_nxt    (state_nxt),
    .res       (res)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      state_r.phase      <= PH_WRITE;
      state_r.lfsr       <= SEED_RESET;
      state_r.word_index <= '0;
      state_r.acc        <= '0;
      state_r.pct        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r    <= in_tdata;
      in_restart_r <= in_tuser;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {5'b00000, out_res_r.finished, out_res_r.percent_stepped,
                       out_res_r.percent, out_res_r.mismatch, out_res_r.write_enable,
                       out_res_r.pattern, out_res_r.word_address};

  a_pass_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_PASS && !(advance && in_restart_r)) |=> state_r.phase == PH_PASS)
    else $error("passed test left its end state without restart");

  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_FAIL && !(advance && in_restart_r)) |=> state_r.phase == PH_FAIL)
    else $error("failed test left its end state without restart");

  a_pct_cap: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> state_r.pct <= PCT_FULL)
    else $error("percent above full scale");

  a_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_res_r.finished ==
                 (state_r.phase == PH_PASS || state_r.phase == PH_FAIL)))
    else $error("finished flag disagrees with phase");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("input register dropped an item");

endmodule

// ===== bench/tb_lfsr_memory_test_engine.sv =====
`timescale 1ns / 100ps

module tb_lfsr_memory_test_engine;
  import lfsrmt_pkg::*;

  localparam int ADDR_W      = 32;
  localparam int ITEMS       = 1650;
  localparam int QUIET_TAIL  = 250;
  localparam int STALL_LIMIT = 1000;

  class mem_test_scoreboard;
    logic [DATA_W-1:0] test_start;
    logic [WC_W-1:0]   word_count;
    logic [DATA_W-1:0] start_seed;
    phase_t            phase;
    logic [DATA_W-1:0] lfsr;
    logic [WC_W-1:0]   idx;
    logic [ACC_W-1:0]  acc;
    logic [PCT_W-1:0]  pct;
    result_t           due_results[$];
    int                errors;

    function new();
      test_start = START_RESET;
      word_count = COUNT_RESET;
      start_seed = SEED_RESET;
      errors = 0;
      restart_run();
    endfunction

    function void restart_run();
      phase = PH_WRITE;
      lfsr = start_seed;
      idx = '0;
      acc = '0;
      pct = '0;
    endfunction

    function void set_reg(cfg_ix_t ix, logic [DATA_W-1:0] v);
      case (ix)
        REG_TEST_START: test_start = v;
        REG_WORD_COUNT: word_count = v[WC_W-1:0];
        REG_START_SEED: start_seed = v;
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] lfsr_advance(logic [DATA_W-1:0] v);
      return (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
    endfunction

    function logic [DATA_W-1:0] word_addr();
      logic [DATA_W-1:0] a;
      a = (test_start & 32'hFFFF_FFFC) + {idx, 2'b00};
      return a & (32'hFFFF_FFFF >> (32 - ADDR_W));
    endfunction

    function logic [DATA_W-1:0] good_read_data();
      return lfsr_advance(lfsr) ^ word_addr();
    endfunction

    function bit verifying();
      return phase == PH_VERIFY && word_count != 0;
    endfunction

    function bit ended();
      return phase == PH_PASS || phase == PH_FAIL;
    endfunction

    function bit advance_progress();
      logic [32:0] sum;
      bit rose;
      sum = {2'b00, acc} + 33'd100;
      rose = 0;
      if (sum >= {3'b000, word_count} && pct < PCT_FULL) begin
        sum = sum - {3'b000, word_count};
        pct = pct + 1'b1;
        rose = 1;
      end
      if (sum > {2'b00, ACC_MAX}) sum = {2'b00, ACC_MAX};
      acc = sum[ACC_W-1:0];
      return rose;
    endfunction

    function void note_item(bit rs, logic [DATA_W-1:0] rd);
      result_t r;
      logic [DATA_W-1:0] nxt;
      r = '0;
      if (rs) begin
        restart_run();
        if (word_count == 0) phase = PH_FAIL;
        r.status = phase;
        r.finished = (phase == PH_FAIL);
      end else if (ended()) begin
        r.status = phase;
        r.finished = 1'b1;
        r.percent = pct;
      end else if (word_count == 0) begin
        phase = PH_FAIL;
        r.status = PH_FAIL;
        r.finished = 1'b1;
      end else begin
        nxt = lfsr_advance(lfsr);
        r.word_address = word_addr();
        r.pattern = nxt ^ r.word_address;
        lfsr = nxt;
        if (phase == PH_VERIFY && rd != r.pattern) begin
          phase = PH_FAIL;
          r.status = PH_FAIL;
          r.mismatch = 1'b1;
          r.finished = 1'b1;
          r.percent = pct;
        end else begin
          r.status = phase;
          r.write_enable = (phase == PH_WRITE);
          r.percent_stepped = advance_progress();
          r.percent = pct;
          idx = idx + 1'b1;
          if (idx >= word_count || idx == 0) begin
            if (phase == PH_WRITE) begin
              phase = PH_VERIFY;
              lfsr = start_seed;
              idx = '0;
              acc = '0;
              pct = '0;
            end else begin
              phase = PH_PASS;
              r.status = PH_PASS;
              r.finished = 1'b1;
            end
          end
        end
      end
      due_results.push_back(r);
    endfunction

    function void compare(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td, logic [1:0] tu);
      result_t want, got;
      if (due_results.size() == 0) begin
        $error("result with no item pending: tdata %h tuser %h", td, tu);
        errors++;
        return;
      end
      want = due_results.pop_front();
      got = {td[74:0], tu};
      compare("status", want.status, got.status);
      compare("word_address", want.word_address, got.word_address);
      compare("pattern", want.pattern, got.pattern);
      compare("write_enable", want.write_enable, got.write_enable);
      compare("mismatch", want.mismatch, got.mismatch);
      compare("percent", want.percent, got.percent);
      compare("percent_stepped", want.percent_stepped, got.percent_stepped);
      compare("finished", want.finished, got.finished);
      compare("padding", '0, td[OUT_TDATA_W-1:75]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_wr_en = 1'b0;
  cfg_ix_t                cfg_index = REG_TEST_START;
  logic [DATA_W-1:0]      cfg_wdata = '0;

  mem_test_scoreboard sb = new();
  int items_sent = 0;
  bit quiet = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  lfsr_memory_test_engine #(.ADDR_WIDTH(ADDR_W)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // result side backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && !quiet && $urandom_range(0, 6) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_word(bit rs, bit corrupt);
    logic [DATA_W-1:0] rd;
    if (sb.verifying() && !rs) begin
      rd = sb.good_read_data();
      if (corrupt) rd = rd ^ (32'h1 << $urandom_range(0, 31));
    end else begin
      rd = $urandom;
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= rs;
    in_tdata <= rd;
    do @(posedge clk); while (!in_tready);
    sb.note_item(rs, rd);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_ix_t ix, logic [DATA_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= v;
    sb.set_reg(ix, v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_words(int n, bit corrupt_last);
    for (int i = 0; i < n; i++) send_word(1'b0, corrupt_last && i == n - 1);
  endtask

  task automatic shuffle_config();
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_TEST_START, 32'h0);
        1: write_reg(REG_TEST_START, 32'hFFFF_FFFC);
        2: write_reg(REG_TEST_START, 32'hFFFF_FF00 | $urandom_range(0, 255));
        default: write_reg(REG_TEST_START, $urandom);
      endcase
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 15))
        0: write_reg(REG_WORD_COUNT, 32'h0);
        1: write_reg(REG_WORD_COUNT, 32'h3FFF_FFFF);
        2: write_reg(REG_WORD_COUNT, $urandom_range(1, 3));
        3: write_reg(REG_WORD_COUNT, $urandom_range(100, 300));
        default: write_reg(REG_WORD_COUNT, $urandom_range(1, 40));
      endcase
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_START_SEED, 32'h0);
        1: write_reg(REG_START_SEED, 32'hFFFF_FFFF);
        default: write_reg(REG_START_SEED, $urandom);
      endcase
    end
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration, first write words
    send_words(2, 0);
    drain();

    // wrapping addresses, low address bits ignored, all-ones seed, full pass
    write_reg(REG_TEST_START, 32'hFFFF_FFFB);
    write_reg(REG_WORD_COUNT, 32'd3);
    write_reg(REG_START_SEED, 32'hFFFF_FFFF);
    send_word(1'b1, 1'b0);
    send_words(6, 0);
    send_word(1'b0, 1'b0);

    // word count lowered mid write phase, then a failing verify word
    send_word(1'b1, 1'b0);
    send_words(1, 0);
    drain();
    write_reg(REG_WORD_COUNT, 32'd1);
    send_words(2, 1);
    send_word(1'b0, 1'b0);
    drain();

    // zero words on restart and while running
    write_reg(REG_WORD_COUNT, 32'd0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    drain();
    write_reg(REG_WORD_COUNT, 32'd2);
    send_word(1'b1, 1'b0);
    drain();
    write_reg(REG_WORD_COUNT, 32'd0);
    send_word(1'b0, 1'b0);
    drain();

    // zero start address and zero seed
    write_reg(REG_TEST_START, 32'h0);
    write_reg(REG_START_SEED, 32'h0);
    write_reg(REG_WORD_COUNT, 32'd2);
    send_word(1'b1, 1'b0);
    send_words(4, 0);

    while (items_sent < ITEMS) begin
      drain();
      shuffle_config();
      if ($urandom_range(0, 3) != 0) send_word(1'b1, 1'b0);
      n = $urandom_range(4, 90);
      for (int i = 0; i < n && items_sent < ITEMS; i++) begin
        quiet = items_sent >= ITEMS - QUIET_TAIL;
        if (sb.ended() && $urandom_range(0, 2) == 0) send_word(1'b1, 1'b0);
        else send_word($urandom_range(0, 39) == 0, $urandom_range(0, 59) == 0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
